@@ design/sha_pkg.sv @@
// ----------------------------------------------------------------------------
// SHA-256 stream digest package
// Shared constants, round table and helper functions.
// ----------------------------------------------------------------------------
package sha_pkg;

  localparam int WordWidth  = 32;
  localparam int CountWidth = 3;
  localparam int FifoDepth  = 4;

  localparam logic [31:0] PadWord = 32'h8000_0000;

  typedef logic [31:0] word_t;

  typedef struct packed {
    logic [31:0] data;
    logic [2:0]  count;
    logic        last;
  } item_t;

  function automatic word_t init_hash(input logic [2:0] idx);
    word_t r;
    case (idx)
      3'd0: r = 32'h6a09e667;
      3'd1: r = 32'hbb67ae85;
      3'd2: r = 32'h3c6ef372;
      3'd3: r = 32'ha54ff53a;
      3'd4: r = 32'h510e527f;
      3'd5: r = 32'h9b05688c;
      3'd6: r = 32'h1f83d9ab;
      default: r = 32'h5be0cd19;
    endcase
    return r;
  endfunction

  function automatic word_t round_k(input logic [5:0] idx);
    word_t r;
    case (idx)
      6'd0: r = 32'h428a2f98; 6'd1: r = 32'h71374491; 6'd2: r = 32'hb5c0fbcf;
      6'd3: r = 32'he9b5dba5; 6'd4: r = 32'h3956c25b; 6'd5: r = 32'h59f111f1;
      6'd6: r = 32'h923f82a4; 6'd7: r = 32'hab1c5ed5; 6'd8: r = 32'hd807aa98;
      6'd9: r = 32'h12835b01; 6'd10: r = 32'h243185be; 6'd11: r = 32'h550c7dc3;
      6'd12: r = 32'h72be5d74; 6'd13: r = 32'h80deb1fe; 6'd14: r = 32'h9bdc06a7;
      6'd15: r = 32'hc19bf174; 6'd16: r = 32'he49b69c1; 6'd17: r = 32'hefbe4786;
      6'd18: r = 32'h0fc19dc6; 6'd19: r = 32'h240ca1cc; 6'd20: r = 32'h2de92c6f;
      6'd21: r = 32'h4a7484aa; 6'd22: r = 32'h5cb0a9dc; 6'd23: r = 32'h76f988da;
      6'd24: r = 32'h983e5152; 6'd25: r = 32'ha831c66d; 6'd26: r = 32'hb00327c8;
      6'd27: r = 32'hbf597fc7; 6'd28: r = 32'hc6e00bf3; 6'd29: r = 32'hd5a79147;
      6'd30: r = 32'h06ca6351; 6'd31: r = 32'h14292967; 6'd32: r = 32'h27b70a85;
      6'd33: r = 32'h2e1b2138; 6'd34: r = 32'h4d2c6dfc; 6'd35: r = 32'h53380d13;
      6'd36: r = 32'h650a7354; 6'd37: r = 32'h766a0abb; 6'd38: r = 32'h81c2c92e;
      6'd39: r = 32'h92722c85; 6'd40: r = 32'ha2bfe8a1; 6'd41: r = 32'ha81a664b;
      6'd42: r = 32'hc24b8b70; 6'd43: r = 32'hc76c51a3; 6'd44: r = 32'hd192e819;
      6'd45: r = 32'hd6990624; 6'd46: r = 32'hf40e3585; 6'd47: r = 32'h106aa070;
      6'd48: r = 32'h19a4c116; 6'd49: r = 32'h1e376c08; 6'd50: r = 32'h2748774c;
      6'd51: r = 32'h34b0bcb5; 6'd52: r = 32'h391c0cb3; 6'd53: r = 32'h4ed8aa4a;
      6'd54: r = 32'h5b9cca4f; 6'd55: r = 32'h682e6ff3; 6'd56: r = 32'h748f82ee;
      6'd57: r = 32'h78a5636f; 6'd58: r = 32'h84c87814; 6'd59: r = 32'h8cc70208;
      6'd60: r = 32'h90befffa; 6'd61: r = 32'ha4506ceb; 6'd62: r = 32'hbef9a3f7;
      default: r = 32'hc67178f2;
    endcase
    return r;
  endfunction

  function automatic word_t ror(input word_t x, input int n);
    return (x >> n) | (x << (32 - n));
  endfunction

endpackage

@@ design/sha_fifo.sv @@
// ----------------------------------------------------------------------------
// SHA-256 item queue
// Short queue between the input side and the block engine.
// ----------------------------------------------------------------------------
module sha_fifo
  import sha_pkg::*;
#(
  parameter int Depth = FifoDepth
) (
  input  logic  clk,
  input  logic  rst,
  input  logic  wr_en,
  input  item_t wr_item,
  output logic  full,
  input  logic  rd_en,
  output item_t rd_item,
  output logic  empty
);

  localparam int AddrWidth = (Depth > 1) ? $clog2(Depth) : 1;

  item_t                mem [Depth];
  logic [AddrWidth-1:0] wr_ptr;
  logic [AddrWidth-1:0] rd_ptr;
  logic [AddrWidth:0]   fill;

  assign full    = (fill == (AddrWidth+1)'(Depth));
  assign empty   = (fill == '0);
  assign rd_item = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (wr_en && !full) begin
      mem[wr_ptr] <= wr_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (wr_en && !full) begin
        wr_ptr <= (wr_ptr == AddrWidth'(Depth - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (rd_en && !empty) begin
        rd_ptr <= (rd_ptr == AddrWidth'(Depth - 1)) ? '0 : rd_ptr + 1'b1;
      end
      fill <= fill + (AddrWidth+1)'(wr_en && !full) - (AddrWidth+1)'(rd_en && !empty);
    end
  end

`ifndef SYNTHESIS
  a_fill_range: assert property (@(posedge clk) disable iff (rst)
    fill <= (AddrWidth+1)'(Depth))
    else $error("fifo fill out of range");
  a_fill_track: assert property (@(posedge clk) disable iff (rst)
    (wr_en && !full && !(rd_en && !empty)) |=> fill == $past(fill) + 1'b1)
    else $error("fifo fill not tracking writes");
  a_no_pop_empty: assert property (@(posedge clk) disable iff (rst)
    empty |=> fill <= 1)
    else $error("fifo underflow");
`endif

endmodule

@@ design/sha_engine.sv @@
// ----------------------------------------------------------------------------
// SHA-256 block engine
// Packs words with padding and length, runs the 64 rounds, emits the digest.
// ----------------------------------------------------------------------------
module sha_engine
  import sha_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        item_valid,
  input  item_t       item,
  output logic        item_take,
  output logic        res_valid,
  input  logic        res_take,
  output logic [63:0] res_d0,
  output logic [63:0] res_d1,
  output logic [63:0] res_d2,
  output logic [63:0] res_d3
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_PAD   = 3'd1;
  localparam logic [2:0] S_ROUND = 3'd2;
  localparam logic [2:0] S_FOLD  = 3'd3;
  localparam logic [2:0] S_EMIT  = 3'd4;

  logic [2:0]  state;
  word_t       chain [8];
  word_t       v [8];
  word_t       w [16];
  logic [3:0]  word_position;
  logic [63:0] len_bits;
  logic [5:0]  round;
  logic        finishing;
  logic        pad_sent;
  logic        len_hi_sent;
  logic        emit_after;

  // pad sequencer
  logic [2:0]  eff_count;
  word_t       mask;
  word_t       push_w;
  logic        push_en;
  logic        pad_done;
  logic        pad_sent_next;
  logic        len_hi_sent_next;

  always_comb begin
    eff_count = (item.count > 3'd4) ? 3'd4 : item.count;
    mask = (eff_count == 3'd0) ? '0 : (32'hffff_ffff << (6'd32 - {eff_count, 3'b000}));
    push_w    = '0;
    push_en   = 1'b0;
    item_take = 1'b0;
    pad_done  = 1'b0;
    pad_sent_next    = pad_sent;
    len_hi_sent_next = len_hi_sent;
    if (state == S_IDLE && item_valid) begin
      item_take = 1'b1;
      push_en   = 1'b1;
      if (!item.last || eff_count == 3'd4) begin
        push_w = item.data;
      end else begin
        push_w = (item.data & mask) | (PadWord >> {eff_count, 3'b000});
        pad_sent_next = 1'b1;
      end
    end else if (state == S_PAD) begin
      push_en = 1'b1;
      if (!pad_sent) begin
        push_w = PadWord;
        pad_sent_next = 1'b1;
      end else if (word_position == 4'd14) begin
        push_w = len_bits[63:32];
        len_hi_sent_next = 1'b1;
      end else if (word_position == 4'd15 && len_hi_sent) begin
        push_w   = len_bits[31:0];
        pad_done = 1'b1;
        len_hi_sent_next = 1'b0;
      end
    end else if (state == S_EMIT && res_take) begin
      pad_sent_next = 1'b0;
    end
  end

  logic [63:0] add_bits;
  assign add_bits = item.last ? 64'({eff_count, 3'b000}) : 64'd32;

  // round datapath
  word_t t1, t2, s0, s1, wn;
  always_comb begin
    t1 = v[7] + (ror(v[4], 6) ^ ror(v[4], 11) ^ ror(v[4], 25))
       + ((v[4] & v[5]) ^ (~v[4] & v[6])) + round_k(round) + w[0];
    t2 = (ror(v[0], 2) ^ ror(v[0], 13) ^ ror(v[0], 22))
       + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
    s0 = ror(w[1], 7) ^ ror(w[1], 18) ^ (w[1] >> 3);
    s1 = ror(w[14], 17) ^ ror(w[14], 19) ^ (w[14] >> 10);
    wn = w[0] + s0 + w[9] + s1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      word_position <= '0;
      len_bits      <= '0;
      round         <= '0;
      finishing     <= 1'b0;
      pad_sent      <= 1'b0;
      len_hi_sent   <= 1'b0;
      emit_after    <= 1'b0;
      for (int i = 0; i < 8; i++) chain[i] <= init_hash(3'(i));
    end else begin
      pad_sent    <= pad_sent_next;
      len_hi_sent <= len_hi_sent_next;
      if (push_en) begin
        w[word_position] <= push_w;
        word_position    <= word_position + 1'b1;
      end
      if (item_take) begin
        len_bits <= len_bits + add_bits;
        if (item.last) finishing <= 1'b1;
      end
      unique case (state)
        S_IDLE: begin
          if (item_take) begin
            if (word_position == 4'd15) begin
              state      <= S_ROUND;
              round      <= '0;
              emit_after <= 1'b0;
              for (int i = 0; i < 8; i++) v[i] <= chain[i];
            end else if (item.last) begin
              state <= S_PAD;
            end
          end
        end
        S_PAD: begin
          if (word_position == 4'd15) begin
            state      <= S_ROUND;
            round      <= '0;
            emit_after <= pad_done;
            for (int i = 0; i < 8; i++) v[i] <= chain[i];
          end
        end
        S_ROUND: begin
          for (int i = 0; i < 15; i++) w[i] <= w[i+1];
          w[15] <= wn;
          v[7] <= v[6]; v[6] <= v[5]; v[5] <= v[4];
          v[4] <= v[3] + t1;
          v[3] <= v[2]; v[2] <= v[1]; v[1] <= v[0];
          v[0] <= t1 + t2;
          round <= round + 1'b1;
          if (round == 6'd63) state <= S_FOLD;
        end
        S_FOLD: begin
          for (int i = 0; i < 8; i++) chain[i] <= chain[i] + v[i];
          if (emit_after) state <= S_EMIT;
          else if (finishing) state <= S_PAD;
          else state <= S_IDLE;
        end
        S_EMIT: begin
          if (res_take) begin
            state     <= S_IDLE;
            finishing <= 1'b0;
            len_bits  <= '0;
            for (int i = 0; i < 8; i++) chain[i] <= init_hash(3'(i));
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign res_valid = (state == S_EMIT);
  assign res_d0 = {chain[0], chain[1]};
  assign res_d1 = {chain[2], chain[3]};
  assign res_d2 = {chain[4], chain[5]};
  assign res_d3 = {chain[6], chain[7]};

`ifndef SYNTHESIS
  a_take_idle: assert property (@(posedge clk) disable iff (rst)
    item_take |-> state == S_IDLE)
    else $error("item taken outside idle");
  a_round_pos: assert property (@(posedge clk) disable iff (rst)
    state == S_ROUND |-> word_position == 4'd0)
    else $error("rounds with partial block");
  a_emit_pos: assert property (@(posedge clk) disable iff (rst)
    state == S_EMIT |-> word_position == 4'd0 && pad_sent)
    else $error("digest before padding finished");
`endif

endmodule

@@ design/sha256_stream_digest_core.sv @@
// ----------------------------------------------------------------------------
// SHA-256 stream digest core
// Channel | dir | transfer when     | payload
// input   | in  | push && !full     | word_data, byte_count, last
// result  | out | pop && !empty     | digest_0..digest_3
// A 4-entry queue takes words while the engine works.
// Each 16th word starts the 64 rounds of one block and then its fold.
// A last item adds filler words in the pad state and up to two compressions.
// Reset is synchronous; the digest holds until popped, stalling the engine.
// ----------------------------------------------------------------------------
module sha256_stream_digest_core
  import sha_pkg::*;
#(
  parameter int QueueDepth = FifoDepth
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  output logic        full,
  input  logic [31:0] word_data,
  input  logic [2:0]  byte_count,
  input  logic        last,
  output logic        empty,
  input  logic        pop,
  output logic [63:0] digest_0,
  output logic [63:0] digest_1,
  output logic [63:0] digest_2,
  output logic [63:0] digest_3
);

  item_t in_item, q_item;
  logic  q_empty, q_take, res_valid;

  assign in_item = '{data: word_data, count: byte_count, last: last};

  sha_fifo #(.Depth(QueueDepth)) u_fifo (
    .clk, .rst,
    .wr_en(push), .wr_item(in_item), .full,
    .rd_en(q_take), .rd_item(q_item), .empty(q_empty)
  );

  sha_engine u_engine (
    .clk, .rst,
    .item_valid(!q_empty), .item(q_item), .item_take(q_take),
    .res_valid, .res_take(pop),
    .res_d0(digest_0), .res_d1(digest_1), .res_d2(digest_2), .res_d3(digest_3)
  );

  assign empty = !res_valid;

endmodule

@@ sim/tb_sha256_stream_digest_core.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// SHA-256 stream digest core testbench
// Feeds messages as word transfers, predicts digests with an independent SHA-256
// model or takes them from stored vectors, and compares every popped digest to them.
// ----------------------------------------------------------------------------
module tb_sha256_stream_digest_core
  import sha_pkg::*;
();

  localparam int WatchLimit = 20000;
  localparam int DrainCycles = 400;
  localparam int DirCount = 10;

  typedef struct packed {
    logic [31:0] data;
    logic [2:0]  count;
    logic        last;
    logic        has_exp;
    logic [255:0] exp_digest;
  } row_t;

  typedef struct {
    logic [63:0] d0, d1, d2, d3;
  } digest_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        push = 1'b0;
  logic        full;
  logic [31:0] word_data = '0;
  logic [2:0]  byte_count = '0;
  logic        last = 1'b0;
  logic        empty;
  logic        pop = 1'b0;
  logic [63:0] digest_0, digest_1, digest_2, digest_3;

  word_t       hash_state[8];
  word_t       msg_block[16];
  int unsigned blk_pos;
  logic [63:0] msg_bits;
  digest_t     digest_q[$];
  int          errors = 0;
  int          idle_cycles = 0;
  bit          quiet = 0;
  bit          hold_pop = 0;

  sha256_stream_digest_core uut (.*);

  always #1 clk = ~clk;

  function automatic word_t rotr(word_t x, int n);
    return (x >> n) | (x << (32 - n));
  endfunction

  task automatic compress();
    word_t w[64];
    word_t a, b, c, d, e, f, g, h, t1, t2;
    for (int i = 0; i < 64; i++) begin
      if (i < 16) w[i] = msg_block[i];
      else w[i] = w[i-16] + (rotr(w[i-15], 7) ^ rotr(w[i-15], 18) ^ (w[i-15] >> 3))
                  + w[i-7] + (rotr(w[i-2], 17) ^ rotr(w[i-2], 19) ^ (w[i-2] >> 10));
    end
    {a, b, c, d, e, f, g, h} = {hash_state[0], hash_state[1], hash_state[2], hash_state[3],
                                hash_state[4], hash_state[5], hash_state[6], hash_state[7]};
    for (int i = 0; i < 64; i++) begin
      t1 = h + (rotr(e, 6) ^ rotr(e, 11) ^ rotr(e, 25)) + ((e & f) ^ (~e & g))
           + round_k(i[5:0]) + w[i];
      t2 = (rotr(a, 2) ^ rotr(a, 13) ^ rotr(a, 22)) + ((a & b) ^ (a & c) ^ (b & c));
      h = g; g = f; f = e; e = d + t1; d = c; c = b; b = a; a = t1 + t2;
    end
    hash_state[0] += a; hash_state[1] += b; hash_state[2] += c; hash_state[3] += d;
    hash_state[4] += e; hash_state[5] += f; hash_state[6] += g; hash_state[7] += h;
  endtask

  task automatic add_word(word_t w);
    msg_block[blk_pos] = w;
    blk_pos = (blk_pos + 1) % 16;
    if (blk_pos == 0) compress();
  endtask

  task automatic rearm();
    for (int i = 0; i < 8; i++) hash_state[i] = init_hash(i[2:0]);
    blk_pos = 0;
    msg_bits = '0;
  endtask

  task automatic predict_word(logic [31:0] data, logic [2:0] count, logic is_last);
    int unsigned n;
    word_t mask;
    digest_t r;
    if (!is_last) begin
      msg_bits += 32;
      add_word(data);
      return;
    end
    n = (count > 4) ? 4 : count;
    msg_bits += n * 8;
    if (n == 4) begin
      add_word(data);
      add_word(PadWord);
    end else begin
      mask = (n == 0) ? '0 : (32'hffff_ffff << (32 - 8 * n));
      add_word((data & mask) | (PadWord >> (8 * n)));
    end
    while (blk_pos != 14) add_word('0);
    add_word(msg_bits[63:32]);
    add_word(msg_bits[31:0]);
    r.d0 = {hash_state[0], hash_state[1]};
    r.d1 = {hash_state[2], hash_state[3]};
    r.d2 = {hash_state[4], hash_state[5]};
    r.d3 = {hash_state[6], hash_state[7]};
    digest_q.insert(digest_q.size(), r);
    rearm();
  endtask

  task automatic send_word(logic [31:0] data, logic [2:0] count, logic is_last, bit predict);
    int gap;
    if (!quiet && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 14);
      push <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    push <= 1'b1;
    word_data <= data;
    byte_count <= count;
    last <= is_last;
    @(posedge clk);
    while (full) @(posedge clk);
    if (predict) predict_word(data, count, is_last);
    @(negedge clk);
  endtask

  task automatic send_message(int unsigned nwords, bit odd_counts);
    logic [2:0] c;
    for (int unsigned i = 0; i < nwords; i++) begin
      c = odd_counts ? 3'($urandom_range(0, 7)) : 3'd4;
      send_word($urandom, c, 1'b0, 1'b1);
    end
    send_word($urandom, 3'($urandom_range(0, 7)), 1'b1, 1'b1);
  endtask

  task automatic wait_drained();
    push <= 1'b0;
    while (digest_q.size() != 0) @(negedge clk);
  endtask

  // result side: random pop stalls, with a long hold window when requested
  always @(negedge clk) begin
    if (rst || hold_pop) pop <= 1'b0;
    else if (!quiet && $urandom_range(0, 7) == 0) begin
      pop <= 1'b0;
      repeat ($urandom_range(1, 14) - 1) @(negedge clk);
    end else pop <= 1'b1;
  end

  always @(posedge clk) begin
    digest_t e;
    if (!rst && pop && !empty) begin
      if (digest_q.size() == 0) begin
        $display("%0t: unexpected digest %h %h %h %h", $time,
                 digest_0, digest_1, digest_2, digest_3);
        errors++;
      end else begin
        e = digest_q.pop_front();
        if (digest_0 !== e.d0) begin
          $display("%0t: digest_0 exp %h got %h", $time, e.d0, digest_0); errors++;
        end
        if (digest_1 !== e.d1) begin
          $display("%0t: digest_1 exp %h got %h", $time, e.d1, digest_1); errors++;
        end
        if (digest_2 !== e.d2) begin
          $display("%0t: digest_2 exp %h got %h", $time, e.d2, digest_2); errors++;
        end
        if (digest_3 !== e.d3) begin
          $display("%0t: digest_3 exp %h got %h", $time, e.d3, digest_3); errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (push && !full) || (pop && !empty)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WatchLimit) begin
      $display("tb_sha256_stream_digest_core failed");
      $finish;
    end
  end

  row_t dir_rows [DirCount];

  initial begin
    int unsigned sent;
    row_t r;
    digest_t dexp;
    rearm();
    // "" and "abc" are the standard vectors; the rest are predicted
    dir_rows[0] = '{32'h0, 3'd0, 1'b1, 1'b1,
      256'he3b0c44298fc1c149afbf4c8996fb92427ae41e4649b934ca495991b7852b855};
    dir_rows[1] = '{32'h6162_63ff, 3'd3, 1'b1, 1'b1,
      256'hba7816bf8f01cfea414140de5dae2223b00361a396177a9cb410ff61f20015ad};
    dir_rows[2] = '{32'hffff_ffff, 3'd4, 1'b1, 1'b0, '0};
    dir_rows[3] = '{32'hffff_ffff, 3'd7, 1'b1, 1'b0, '0};
    dir_rows[4] = '{32'hffff_ffff, 3'd1, 1'b1, 1'b0, '0};
    dir_rows[5] = '{32'hffff_ffff, 3'd2, 1'b1, 1'b0, '0};
    dir_rows[6] = '{32'hffff_ffff, 3'd5, 1'b0, 1'b0, '0};
    dir_rows[7] = '{32'h0000_0000, 3'd0, 1'b0, 1'b0, '0};
    dir_rows[8] = '{32'hdead_beef, 3'd4, 1'b0, 1'b0, '0};
    dir_rows[9] = '{32'h0123_4567, 3'd6, 1'b1, 1'b0, '0};
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    for (int i = 0; i < DirCount; i++) begin
      r = dir_rows[i];
      if (r.has_exp) begin
        dexp.d0 = r.exp_digest[255:192];
        dexp.d1 = r.exp_digest[191:128];
        dexp.d2 = r.exp_digest[127:64];
        dexp.d3 = r.exp_digest[63:0];
        digest_q.insert(digest_q.size(), dexp);
        send_word(r.data, r.count, r.last, 1'b0);
      end else begin
        send_word(r.data, r.count, r.last, 1'b1);
      end
    end
    wait_drained();
    sent = DirCount;
    // long messages: 13..16 full words and a last item; some need the extra pad block
    for (int k = 13; k <= 16; k++) begin
      send_message(k, 1'b0);
      sent += k + 1;
    end
    // hold results so the queue fills and push stalls
    hold_pop = 1;
    fork
      begin
        repeat (600) @(negedge clk);
        hold_pop = 0;
      end
      for (int k = 0; k < 6; k++) send_message($urandom_range(0, 4), 1'b0);
    join
    wait_drained();
    while (sent < 800) begin
      int unsigned n;
      n = ($urandom_range(0, 9) == 0) ? $urandom_range(16, 70) : $urandom_range(0, 20);
      if (sent > 700) quiet = 1;
      send_message(n, $urandom_range(0, 9) == 0);
      sent += n + 1;
    end
    push <= 1'b0;
    wait_drained();
    repeat (DrainCycles) @(negedge clk);
    if (errors == 0) $display("tb_sha256_stream_digest_core passed");
    else $display("tb_sha256_stream_digest_core failed");
    $finish;
  end

endmodule

@@ filelist.f @@
design/sha_pkg.sv
design/sha_fifo.sv
design/sha_engine.sv
design/sha256_stream_digest_core.sv
sim/tb_sha256_stream_digest_core.sv
